>>> hw/rtl/rzm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rzm_pkg
// Shared types and constants of the rotozoom texture mapper.
// ----------------------------------------------------------------------------
package rzm_pkg;

  localparam int TEX_WIDTH_LOG2_DEF  = 6;
  localparam int TEX_HEIGHT_LOG2_DEF = 6;
  localparam int PIXEL_BITS_DEF      = 24;

  localparam int STEP_W   = 16;
  localparam int DIM_W    = 10;
  localparam int ACC_W    = 32;
  localparam int FRAC_W   = 8;
  localparam int ADDR_W   = 12;
  localparam int TEXEL_W  = 24;

  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 48;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  localparam logic MODE_TEXEL = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  localparam logic [STEP_W-1:0] STEP_X_RST       = 16'd256;
  localparam logic [STEP_W-1:0] STEP_Y_RST       = 16'd0;
  localparam logic [DIM_W-1:0]  FRAME_WIDTH_RST  = 10'd320;
  localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RST = 10'd240;

  typedef enum logic [1:0] {
    REG_STEP_X,
    REG_STEP_Y,
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT
  } rzm_reg_t;

  typedef struct packed {
    logic signed [STEP_W-1:0] step_x;
    logic signed [STEP_W-1:0] step_y;
    logic [DIM_W-1:0]         frame_width;
    logic [DIM_W-1:0]         frame_height;
  } rzm_cfg_t;

  typedef struct packed {
    logic [DIM_W-1:0] dest_x;
    logic [DIM_W-1:0] dest_y;
    logic             row_end;
    logic             frame_end;
  } rzm_meta_t;

endpackage
`default_nettype wire

>>> hw/rtl/rzm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rzm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rzm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/rzm_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rzm_regs
// APB configuration registers: steps and frame size.
// ----------------------------------------------------------------------------
module rzm_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rzm_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [rzm_pkg::CFG_DW-1:0]   pwdata,
  output logic      [rzm_pkg::CFG_DW-1:0]   prdata,
  output logic                              pready,
  output rzm_pkg::rzm_cfg_t                 cfg
);
  import rzm_pkg::*;

  rzm_reg_t sel;
  logic     wr;

  assign sel    = rzm_reg_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_x       <= STEP_X_RST;
      cfg.step_y       <= STEP_Y_RST;
      cfg.frame_width  <= FRAME_WIDTH_RST;
      cfg.frame_height <= FRAME_HEIGHT_RST;
    end else if (wr) begin
      case (sel)
        REG_STEP_X:       cfg.step_x       <= pwdata[STEP_W-1:0];
        REG_STEP_Y:       cfg.step_y       <= pwdata[STEP_W-1:0];
        REG_FRAME_WIDTH:  cfg.frame_width  <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_STEP_X:       prdata = CFG_DW'(cfg.step_x);
      REG_STEP_Y:       prdata = CFG_DW'(cfg.step_y);
      REG_FRAME_WIDTH:  prdata = CFG_DW'(cfg.frame_width);
      REG_FRAME_HEIGHT: prdata = CFG_DW'(cfg.frame_height);
      default:          prdata = '0;
    endcase
  end

  a_step_x_write: assert property (@(posedge clk) disable iff (rst)
    wr && (sel == REG_STEP_X) |=> cfg.step_x == $past(pwdata[STEP_W-1:0]))
    else $error("step_x write lost");

  a_width_write: assert property (@(posedge clk) disable iff (rst)
    wr && (sel == REG_FRAME_WIDTH) |=> cfg.frame_width == $past(pwdata[DIM_W-1:0]))
    else $error("frame_width write lost");

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !wr |=> $stable(cfg))
    else $error("config changed without write");

endmodule
`default_nettype wire

>>> hw/rtl/rzm_walk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rzm_walk
// Source coordinate walker: accumulators, raster counters, texel address.
// ----------------------------------------------------------------------------
module rzm_walk #(
  parameter int TEX_WIDTH_LOG2  = rzm_pkg::TEX_WIDTH_LOG2_DEF,
  parameter int TEX_HEIGHT_LOG2 = rzm_pkg::TEX_HEIGHT_LOG2_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      advance,
  input  wire rzm_pkg::rzm_cfg_t                         cfg,
  output logic [TEX_WIDTH_LOG2+TEX_HEIGHT_LOG2-1:0]      raddr,
  output rzm_pkg::rzm_meta_t                             meta
);
  import rzm_pkg::*;

  logic [ACC_W-1:0] src_x, src_y, row_x, row_y;
  logic [ACC_W-1:0] src_x_next, src_y_next, row_x_next, row_y_next;
  logic [DIM_W-1:0] col, row, col_next, row_next;
  logic [ACC_W-1:0] sx, sy;
  logic [DIM_W:0]   col_inc, row_inc;

  assign sx = ACC_W'(cfg.step_x);
  assign sy = ACC_W'(cfg.step_y);

  assign raddr = {src_y[FRAC_W +: TEX_HEIGHT_LOG2], src_x[FRAC_W +: TEX_WIDTH_LOG2]};

  assign col_inc        = {1'b0, col} + 1'b1;
  assign row_inc        = {1'b0, row} + 1'b1;
  assign meta.dest_x    = col;
  assign meta.dest_y    = row;
  assign meta.row_end   = col_inc >= {1'b0, cfg.frame_width};
  assign meta.frame_end = meta.row_end && (row_inc >= {1'b0, cfg.frame_height});

  always_comb begin
    src_x_next = src_x + sx;
    src_y_next = src_y + sy;
    row_x_next = row_x;
    row_y_next = row_y;
    col_next   = col_inc[DIM_W-1:0];
    row_next   = row;
    if (meta.frame_end) begin
      src_x_next = '0;
      src_y_next = '0;
      row_x_next = '0;
      row_y_next = '0;
      col_next   = '0;
      row_next   = '0;
    end else if (meta.row_end) begin
      row_x_next = row_x - sy;
      row_y_next = row_y + sx;
      src_x_next = row_x_next;
      src_y_next = row_y_next;
      col_next   = '0;
      row_next   = row_inc[DIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_x <= '0;
      src_y <= '0;
      row_x <= '0;
      row_y <= '0;
      col   <= '0;
      row   <= '0;
    end else if (advance) begin
      src_x <= src_x_next;
      src_y <= src_y_next;
      row_x <= row_x_next;
      row_y <= row_y_next;
      col   <= col_next;
      row   <= row_next;
    end
  end

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    advance && meta.frame_end |=> (col == '0) && (row == '0) && (src_x == '0))
    else $error("walker not cleared after frame end");

  a_row_restart: assert property (@(posedge clk) disable iff (rst)
    advance && meta.row_end && !meta.frame_end |=> (col == '0) && (src_x == row_x))
    else $error("row did not restart at row start");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col != {DIM_W{1'b1}})
    else $error("column counter out of range");

endmodule
`default_nettype wire

>>> hw/rtl/rotozoom_texture_mapper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rotozoom_texture_mapper
// Rotating and zooming affine texture mapper.
//
// Slave stream: s_tuser = 0 writes one texel to the texture RAM (no output),
// s_tuser = 1 produces the next destination pixel in raster order.
// Master stream: one transaction per pixel; m_tlast marks the last pixel of
// a row, m_tuser the last pixel of the frame.
// APB port: step_x at 0x0, step_y at 0x4, frame_width at 0x8, frame_height
// at 0xC. Write only while the stream is idle.
// Throughput: one transaction per cycle on both streams while m_tready is high.
// An accepted pixel passes through the registered read of the texture RAM
// and then the output register before it shows on m_tvalid.
// Reset clears the walker and loads the default steps and frame size; the
// texture RAM keeps its contents and must be loaded before pixels are read.
// When the receiver stalls, the output register and one stage behind it
// hold; s_tready drops once both are full.
// ----------------------------------------------------------------------------
module rotozoom_texture_mapper #(
  parameter int TEX_WIDTH_LOG2  = rzm_pkg::TEX_WIDTH_LOG2_DEF,
  parameter int TEX_HEIGHT_LOG2 = rzm_pkg::TEX_HEIGHT_LOG2_DEF,
  parameter int PIXEL_BITS      = rzm_pkg::PIXEL_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // texel_address [11:0], texel_value [35:12], zero [39:36]
  input  wire logic [rzm_pkg::S_DATA_W-1:0]   s_tdata,
  // mode [0]
  input  wire logic                           s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // pixel_value [23:0], dest_x [33:24], dest_y [43:34], zero [47:44]
  output logic      [rzm_pkg::M_DATA_W-1:0]   m_tdata,
  output logic                                m_tlast,
  // frame_end [0]
  output logic                                m_tuser,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [rzm_pkg::CFG_AW-1:0]     paddr,
  input  wire logic [rzm_pkg::CFG_DW-1:0]     pwdata,
  output logic      [rzm_pkg::CFG_DW-1:0]     prdata,
  output logic                                pready
);
  import rzm_pkg::*;

  localparam int AW    = TEX_WIDTH_LOG2 + TEX_HEIGHT_LOG2;
  localparam int DEPTH = 1 << AW;
  localparam int PW    = (PIXEL_BITS < TEXEL_W) ? PIXEL_BITS : TEXEL_W;

  rzm_cfg_t          cfg;
  rzm_meta_t         walk_meta, s1_meta, out_meta;
  logic [AW-1:0]     raddr, waddr;
  logic [AW+ADDR_W-1:0] waddr_ext;
  logic [PW-1:0]     rdata;
  logic [TEXEL_W-1:0] out_pix;
  logic              accept, pix_go, tex_go, out_adv;
  logic              s1_valid, out_valid;

  rzm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign out_adv  = !out_valid || m_tready;
  assign s_tready = !s1_valid || out_adv;
  assign accept   = s_tvalid && s_tready;
  assign pix_go   = accept && (s_tuser == MODE_PIXEL);
  assign tex_go   = accept && (s_tuser == MODE_TEXEL);

  assign waddr_ext = {{AW{1'b0}}, s_tdata[ADDR_W-1:0]};
  assign waddr     = waddr_ext[AW-1:0];

  rzm_walk #(
    .TEX_WIDTH_LOG2  (TEX_WIDTH_LOG2),
    .TEX_HEIGHT_LOG2 (TEX_HEIGHT_LOG2)
  ) u_walk (
    .clk     (clk),
    .rst     (rst),
    .advance (pix_go),
    .cfg     (cfg),
    .raddr   (raddr),
    .meta    (walk_meta)
  );

  rzm_ram #(
    .WIDTH (PW),
    .DEPTH (DEPTH)
  ) u_tex_ram (
    .clk   (clk),
    .we    (tex_go),
    .waddr (waddr),
    .wdata (s_tdata[ADDR_W +: PW]),
    .re    (pix_go),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        s1_valid <= pix_go;
      end
      if (out_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_go) begin
      s1_meta <= walk_meta;
    end
    if (out_adv && s1_valid) begin
      out_meta <= s1_meta;
      out_pix  <= TEXEL_W'(rdata);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0, out_meta.dest_y, out_meta.dest_x, out_pix};
  assign m_tlast  = out_meta.row_end;
  assign m_tuser  = out_meta.frame_end;

  a_pix_enters: assert property (@(posedge clk) disable iff (rst)
    pix_go |=> s1_valid)
    else $error("accepted pixel missing from read stage");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_adv |=> s1_valid && $stable(s1_meta))
    else $error("read stage lost data under stall");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> s_tready)
    else $error("stream stalled with empty read stage");

  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_meta.frame_end |-> out_meta.row_end)
    else $error("frame end without row end");

endmodule
`default_nettype wire

>>> tb/rotozoom_texture_mapper_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotozoom_texture_mapper_checker
// Passive checker for the rotozoom texture mapper. It watches the texel/pixel
// input stream, the pixel output stream and the APB port. It keeps its own
// copy of the texture memory, the registers and the raster walker, works out
// each pixel when its request is accepted, and compares every output
// transaction field by field with the oldest predicted pixel.
// ----------------------------------------------------------------------------
module rotozoom_texture_mapper_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [rzm_pkg::S_DATA_W-1:0] s_tdata,
  input  logic                         s_tuser,
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [rzm_pkg::M_DATA_W-1:0] m_tdata,
  input  logic                         m_tlast,
  input  logic                         m_tuser,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rzm_pkg::CFG_AW-1:0]   paddr,
  input  logic [rzm_pkg::CFG_DW-1:0]   pwdata,
  input  logic                         pready,
  output int unsigned                  pending,
  output int unsigned                  fail_count
);

  localparam int TW     = rzm_pkg::TEX_WIDTH_LOG2_DEF;
  localparam int TH     = rzm_pkg::TEX_HEIGHT_LOG2_DEF;
  localparam int TEXELS = 1 << (TW + TH);
  localparam int ACC_W  = rzm_pkg::ACC_W;
  localparam int STEP_W = rzm_pkg::STEP_W;
  localparam int DIM_W  = rzm_pkg::DIM_W;

  typedef struct packed {
    logic [rzm_pkg::TEXEL_W-1:0] pixel;
    rzm_pkg::rzm_meta_t          meta;
  } pixel_t;

  logic [rzm_pkg::TEXEL_W-1:0] texels [TEXELS];
  rzm_pkg::rzm_cfg_t           cfg;
  logic [ACC_W-1:0]            src_x, src_y, row_x, row_y;
  logic [DIM_W-1:0]            col_cnt, row_cnt;
  pixel_t                      pixel_q[$];

  function automatic void clear_walker();
    src_x   = '0;
    src_y   = '0;
    row_x   = '0;
    row_y   = '0;
    col_cnt = '0;
    row_cnt = '0;
  endfunction

  function automatic pixel_t next_pixel();
    pixel_t           px;
    logic [ACC_W-1:0] dx, dy;
    logic [TW-1:0]    tx;
    logic [TH-1:0]    ty;
    dx = {{(ACC_W-STEP_W){cfg.step_x[STEP_W-1]}}, cfg.step_x};
    dy = {{(ACC_W-STEP_W){cfg.step_y[STEP_W-1]}}, cfg.step_y};
    tx = src_x[rzm_pkg::FRAC_W +: TW];
    ty = src_y[rzm_pkg::FRAC_W +: TH];
    px.pixel          = texels[{ty, tx}];
    px.meta.dest_x    = col_cnt;
    px.meta.dest_y    = row_cnt;
    px.meta.row_end   = (int'(col_cnt) + 1) >= int'(cfg.frame_width);
    px.meta.frame_end = px.meta.row_end && ((int'(row_cnt) + 1) >= int'(cfg.frame_height));
    if (px.meta.frame_end) begin
      clear_walker();
    end else if (px.meta.row_end) begin
      row_x   = row_x - dy;
      row_y   = row_y + dx;
      src_x   = row_x;
      src_y   = row_y;
      col_cnt = '0;
      row_cnt = row_cnt + 1'b1;
    end else begin
      src_x   = src_x + dx;
      src_y   = src_y + dy;
      col_cnt = col_cnt + 1'b1;
    end
    return px;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    pixel_t got, want;
    if (rst) begin
      cfg.step_x       = rzm_pkg::STEP_X_RST;
      cfg.step_y       = rzm_pkg::STEP_Y_RST;
      cfg.frame_width  = rzm_pkg::FRAME_WIDTH_RST;
      cfg.frame_height = rzm_pkg::FRAME_HEIGHT_RST;
      clear_walker();
      pixel_q.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (rzm_pkg::rzm_reg_t'(paddr[rzm_pkg::CFG_AW-1:2]))
          rzm_pkg::REG_STEP_X:       cfg.step_x       = pwdata[STEP_W-1:0];
          rzm_pkg::REG_STEP_Y:       cfg.step_y       = pwdata[STEP_W-1:0];
          rzm_pkg::REG_FRAME_WIDTH:  cfg.frame_width  = pwdata[DIM_W-1:0];
          rzm_pkg::REG_FRAME_HEIGHT: cfg.frame_height = pwdata[DIM_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.pixel          = m_tdata[23:0];
        got.meta.dest_x    = m_tdata[33:24];
        got.meta.dest_y    = m_tdata[43:34];
        got.meta.row_end   = m_tlast;
        got.meta.frame_end = m_tuser;
        if (pixel_q.size() == 0) begin
          $error("output transaction with no pixel request outstanding");
          fail_count++;
        end else begin
          want = pixel_q.pop_front();
          check_field("pixel_value", 32'(want.pixel), 32'(got.pixel));
          check_field("dest_x", 32'(want.meta.dest_x), 32'(got.meta.dest_x));
          check_field("dest_y", 32'(want.meta.dest_y), 32'(got.meta.dest_y));
          check_field("row_end", 32'(want.meta.row_end), 32'(got.meta.row_end));
          check_field("frame_end", 32'(want.meta.frame_end), 32'(got.meta.frame_end));
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == rzm_pkg::MODE_TEXEL) begin
          texels[s_tdata[rzm_pkg::ADDR_W-1:0]] = s_tdata[rzm_pkg::ADDR_W +: rzm_pkg::TEXEL_W];
        end else begin
          pixel_q.push_back(next_pixel());
        end
      end
    end
    pending <= pixel_q.size();
  end

endmodule

>>> tb/rotozoom_texture_mapper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotozoom_texture_mapper_tb
// Stimulus and verdict for the rotozoom texture mapper. The whole texture is
// loaded first, then a directed set of frame sizes and steps (zero, extreme
// and shrunken settings) and several random register settings are run. Most
// run with random gaps on both streams; the random ones mix in texel writes
// and one has a long output stall. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module rotozoom_texture_mapper_tb;

  localparam int TEXELS          = 1 << (rzm_pkg::TEX_WIDTH_LOG2_DEF + rzm_pkg::TEX_HEIGHT_LOG2_DEF);
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int LONG_STALL      = 300;
  localparam int CYCLE_LIMIT     = 300000;

  logic                         clk;
  logic                         rst;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [rzm_pkg::S_DATA_W-1:0] s_tdata;
  logic                         s_tuser;
  logic                         m_tvalid;
  logic                         m_tready;
  logic [rzm_pkg::M_DATA_W-1:0] m_tdata;
  logic                         m_tlast;
  logic                         m_tuser;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [rzm_pkg::CFG_AW-1:0]   paddr;
  logic [rzm_pkg::CFG_DW-1:0]   pwdata;
  logic [rzm_pkg::CFG_DW-1:0]   prdata;
  logic                         pready;
  int unsigned                  pending;
  int unsigned                  fail_count;

  bit          calm;
  int unsigned stall_cycles;
  int unsigned cycles;
  int unsigned texel_writes;
  int unsigned pixel_reqs;
  int unsigned settings;

  rotozoom_texture_mapper i_dut (.*);

  rotozoom_texture_mapper_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels outstanding", cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // output side: random backpressure plus one long hold
  initial begin
    int unsigned gap;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = calm ? 0 : $urandom_range(12, 0);
      if (stall_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (stall_cycles) @(posedge clk);
        stall_cycles = 0;
      end else if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  task automatic stream_item(input logic mode, input logic [rzm_pkg::ADDR_W-1:0] addr,
                             input logic [rzm_pkg::TEXEL_W-1:0] value);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(12, 0);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {{(rzm_pkg::S_DATA_W-rzm_pkg::ADDR_W-rzm_pkg::TEXEL_W){1'b0}}, value, addr};
    do @(posedge clk); while (!s_tready);
    if (mode == rzm_pkg::MODE_TEXEL) texel_writes++;
    else pixel_reqs++;
  endtask

  task automatic write_texel(input logic [rzm_pkg::ADDR_W-1:0] addr,
                             input logic [rzm_pkg::TEXEL_W-1:0] value);
    stream_item(rzm_pkg::MODE_TEXEL, addr, value);
  endtask

  task automatic request_pixel();
    stream_item(rzm_pkg::MODE_PIXEL, rzm_pkg::ADDR_W'($urandom),
                rzm_pkg::TEXEL_W'($urandom));
  endtask

  // drop valid, wait for every pixel, then let in-flight texel writes land
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input rzm_pkg::rzm_reg_t idx, input logic [rzm_pkg::CFG_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] sx, input logic [15:0] sy,
                           input logic [9:0] w, input logic [9:0] h);
    write_reg(rzm_pkg::REG_STEP_X, {16'b0, sx});
    write_reg(rzm_pkg::REG_STEP_Y, {16'b0, sy});
    write_reg(rzm_pkg::REG_FRAME_WIDTH, {22'b0, w});
    write_reg(rzm_pkg::REG_FRAME_HEIGHT, {22'b0, h});
    settings++;
  endtask

  function automatic logic [15:0] pick_step();
    case ($urandom_range(3, 0))
      0:       return ($urandom_range(1, 0) != 0) ? 16'h8000 : 16'h7FFF;
      1:       return 16'($urandom_range(1024, 0)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [9:0] pick_dim(input int unsigned max_small);
    if ($urandom_range(7, 0) == 0) return 10'($urandom);
    return 10'($urandom_range(max_small, 0));
  endfunction

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= rzm_pkg::MODE_TEXEL;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    calm         = 1'b1;
    stall_cycles = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int a = 0; a < TEXELS; a++) begin
      write_texel(a[rzm_pkg::ADDR_W-1:0], rzm_pkg::TEXEL_W'($urandom));
    end
    calm = 1'b0;
    settle();

    configure(16'd256, 16'd0, 10'd3, 10'd2);
    write_texel('0, '0);
    write_texel('1, 24'hFFFFFF);
    write_texel(12'd1, rzm_pkg::TEXEL_W'($urandom));
    repeat (7) request_pixel();
    settle();
    configure(16'h8000, 16'h7FFF, 10'd0, 10'd3);
    repeat (4) request_pixel();
    settle();
    configure(16'h7FFF, 16'h8000, 10'd1023, 10'd1023);
    repeat (5) request_pixel();
    settle();
    configure(16'h7FFF, 16'h8000, 10'd2, 10'd1);
    repeat (2) request_pixel();

    for (int p = 0; p < PHASES; p++) begin
      settle();
      configure(pick_step(), pick_step(), pick_dim(12), pick_dim(6));
      calm = (p == 5);
      if (p == 2) stall_cycles = LONG_STALL;
      repeat (ITEMS_PER_PHASE) begin
        if ($urandom_range(99, 0) < 15) begin
          write_texel(rzm_pkg::ADDR_W'($urandom), rzm_pkg::TEXEL_W'($urandom));
        end else begin
          request_pixel();
        end
      end
    end

    settle();
    repeat (16) @(posedge clk);
    $display("ran %0d texel writes and %0d pixel requests over %0d register settings",
             texel_writes, pixel_reqs, settings);
    $display("with extreme steps, zero, full and shrunken frame sizes and a long output stall");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
